### hw/rtl/u3wb_pkg.sv
package u3wb_pkg;

  localparam int BURST_BYTES = 8;
  localparam int BC_W = (BURST_BYTES > 1) ? $clog2(BURST_BYTES) : 1;

  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW = $clog2(JQ_DEPTH);

  localparam int STEP_W = 4;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  localparam logic [7:0] CMD_ID     = 8'h00;
  localparam logic [7:0] CMD_RD_CLK = 8'h01;
  localparam logic [7:0] CMD_WR_CLK = 8'h02;
  localparam logic [7:0] CMD_RD_RAM = 8'h03;
  localparam logic [7:0] CMD_WR_RAM = 8'h04;

  localparam logic [7:0] CODE_RD_CLK = 8'hBF;
  localparam logic [7:0] CODE_RD_RAM = 8'hFF;
  localparam logic [7:0] CODE_WR_CLK = 8'hBE;
  localparam logic [7:0] CODE_WR_RAM = 8'hFE;
  localparam logic [7:0] ID_BYTE     = 8'h39;

  localparam logic [1:0] KIND_TX  = 2'd0;
  localparam logic [1:0] KIND_CE  = 2'd1;
  localparam logic [1:0] KIND_CLK = 2'd2;
  localparam logic [1:0] KIND_DRV = 2'd3;

  localparam logic [1:0] OP_ID     = 2'd0;
  localparam logic [1:0] OP_SHIFT  = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic       pulse;
    logic [7:0] data;
    logic       done;
    logic       fin;
  } job_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       io_bit;
    logic       io_drive;
    logic       last;
  } result_t;

endpackage

### hw/rtl/u3wb_front.sv
module u3wb_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic          func,
  input  logic [7:0]    rx_byte,
  input  logic          line_bit,
  output logic          job_push,
  output u3wb_pkg::job_t job
);
  import u3wb_pkg::*;

  logic [1:0]      mode_r, mode_nxt;
  logic [BC_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [2:0]      bit_cnt_r, bit_cnt_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic [7:0]      new_shift;
  logic            byte_done;
  logic            burst_end;
  logic            has_job;

  assign new_shift = {line_bit, shift_r[7:1]};
  assign byte_done = (bit_cnt_r == 3'd7);
  assign burst_end = (byte_cnt_r == BC_W'(BURST_BYTES - 1));

  always_comb begin
    mode_nxt     = mode_r;
    byte_cnt_nxt = byte_cnt_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    has_job      = 1'b0;
    job          = '0;
    case (mode_r)
      MODE_READ: begin
        if (func) begin
          has_job  = 1'b1;
          job.op   = OP_SAMPLE;
          job.data = new_shift;
          job.done = byte_done;
          job.fin  = byte_done && burst_end;
          if (byte_done) begin
            bit_cnt_nxt = 3'd0;
            shift_nxt   = 8'd0;
            if (burst_end) begin
              byte_cnt_nxt = '0;
              mode_nxt     = MODE_IDLE;
            end else begin
              byte_cnt_nxt = byte_cnt_r + 1'b1;
            end
          end else begin
            bit_cnt_nxt = bit_cnt_r + 3'd1;
            shift_nxt   = new_shift;
          end
        end
      end
      MODE_WRITE: begin
        if (!func) begin
          has_job  = 1'b1;
          job.op   = OP_SHIFT;
          job.data = rx_byte;
          if (burst_end) begin
            byte_cnt_nxt = '0;
            mode_nxt     = MODE_IDLE;
          end else begin
            byte_cnt_nxt = byte_cnt_r + 1'b1;
          end
        end
      end
      default: begin
        if (!func) begin
          mode_nxt = MODE_IDLE;
          case (rx_byte)
            CMD_ID: begin
              has_job = 1'b1;
              job.op  = OP_ID;
            end
            CMD_RD_CLK, CMD_RD_RAM: begin
              has_job      = 1'b1;
              job.op       = OP_SHIFT;
              job.pulse    = 1'b1;
              job.data     = (rx_byte == CMD_RD_CLK) ? CODE_RD_CLK : CODE_RD_RAM;
              mode_nxt     = MODE_READ;
              byte_cnt_nxt = '0;
              bit_cnt_nxt  = 3'd0;
              shift_nxt    = 8'd0;
            end
            CMD_WR_CLK, CMD_WR_RAM: begin
              has_job      = 1'b1;
              job.op       = OP_SHIFT;
              job.pulse    = 1'b1;
              job.data     = (rx_byte == CMD_WR_CLK) ? CODE_WR_CLK : CODE_WR_RAM;
              mode_nxt     = MODE_WRITE;
              byte_cnt_nxt = '0;
              bit_cnt_nxt  = 3'd0;
            end
            default: begin
            end
          endcase
        end
      end
    endcase
  end

  assign job_push = acc && has_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      byte_cnt_r <= '0;
      bit_cnt_r  <= 3'd0;
      shift_r    <= 8'd0;
    end else if (acc) begin
      mode_r     <= mode_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
    end
  end

endmodule

### hw/rtl/u3wb_jobq.sv
module u3wb_jobq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  u3wb_pkg::job_t wr_job,
  input  logic           pop,
  output u3wb_pkg::job_t head,
  output logic           empty,
  output logic           full
);
  import u3wb_pkg::*;

  job_t             ent_r [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [JQ_AW:0]   cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (JQ_AW + 1)'(JQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

### hw/rtl/u3wb_back.sv
module u3wb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  u3wb_pkg::job_t    job,
  input  logic              job_empty,
  output logic              job_pop,
  output u3wb_pkg::result_t res,
  output logic              res_valid,
  input  logic              res_pop
);
  import u3wb_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  result_t           out_r;
  result_t           cur;
  logic              adv;
  logic [2:0]        bit_idx;

  assign bit_idx = step_r[2:0] - {2'b00, job.pulse};

  always_comb begin
    cur = '0;
    case (job.op)
      OP_ID: begin
        cur.kind     = KIND_TX;
        cur.tx_byte  = ID_BYTE;
        cur.io_drive = 1'b1;
        cur.last     = (step_r == STEP_W'(7));
      end
      OP_SHIFT: begin
        cur.io_drive = 1'b1;
        if (job.pulse && step_r == '0) begin
          cur.kind = KIND_CE;
        end else begin
          cur.kind   = KIND_CLK;
          cur.io_bit = job.data[bit_idx];
          cur.last   = job.pulse ? (step_r == STEP_W'(8)) : (step_r == STEP_W'(7));
        end
      end
      OP_SAMPLE: begin
        if (step_r == '0) begin
          cur.kind = KIND_CLK;
          cur.last = !job.done;
        end else if (step_r == STEP_W'(1) && job.fin) begin
          cur.kind     = KIND_DRV;
          cur.io_drive = 1'b1;
        end else begin
          cur.kind     = KIND_TX;
          cur.tx_byte  = job.data;
          cur.io_drive = job.fin;
          cur.last     = 1'b1;
        end
      end
      default: begin
        cur.last = 1'b1;
      end
    endcase
  end

  assign adv       = !job_empty && (!out_valid_r || res_pop);
  assign job_pop   = adv && cur.last;
  assign res       = out_r;
  assign res_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        step_r      <= cur.last ? '0 : step_r + 1'b1;
      end else if (res_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/uart_to_three_wire_burst_bridge_unit.sv
// channel   ports                                          direction
// input     in_push, in_full, in_func, in_rx_byte,         in
//           in_line_bit
// result    out_empty, out_pop, out_kind, out_tx_byte,     out
//           out_io_bit, out_io_drive, out_last
//
// one input item per cycle while the four-entry job queue has room
// the back-end sequencer issues one result per cycle while the output
// register is empty or being popped; an item causes 0 to 9 results
// rst_n is synchronous: clears mode, counters, job queue and output valid flag
// pop low holds the output register; the back end then stops, the queue
// fills and in_full rises
module uart_to_three_wire_burst_bridge_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_func,
  input  logic [7:0] in_rx_byte,
  input  logic       in_line_bit,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_tx_byte,
  output logic       out_io_bit,
  output logic       out_io_drive,
  output logic       out_last
);
  import u3wb_pkg::*;

  logic    acc;
  logic    job_push;
  job_t    job_in;
  job_t    job_head;
  logic    job_empty;
  logic    job_pop;
  result_t res;
  logic    res_valid;

  assign acc = in_push && !in_full;

  u3wb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .func     (in_func),
    .rx_byte  (in_rx_byte),
    .line_bit (in_line_bit),
    .job_push (job_push),
    .job      (job_in)
  );

  u3wb_jobq u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .wr_job (job_in),
    .pop    (job_pop),
    .head   (job_head),
    .empty  (job_empty),
    .full   (in_full)
  );

  u3wb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_head),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (out_pop)
  );

  assign out_empty    = !res_valid;
  assign out_kind     = res.kind;
  assign out_tx_byte  = res.tx_byte;
  assign out_io_bit   = res.io_bit;
  assign out_io_drive = res.io_drive;
  assign out_last     = res.last;

endmodule

### tb/sv/u3wb_event_checker.sv
`timescale 1ns / 100ps

module u3wb_event_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  logic       in_func,
  input  logic [7:0] in_rx_byte,
  input  logic       in_line_bit,
  input  logic       out_empty,
  input  logic       out_pop,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_tx_byte,
  input  logic       out_io_bit,
  input  logic       out_io_drive,
  input  logic       out_last,
  output int         errors,
  output int         waiting
);
  import u3wb_pkg::*;

  localparam int PRINT_CAP = 60;

  logic [1:0]  bridge_mode;
  int unsigned burst_byte_idx;
  logic [2:0]  burst_bit_idx;
  logic [7:0]  read_shift;

  result_t item_events[$];
  result_t wire_events_due[$];

  int fails = 0;
  int backlog = 0;

  assign errors  = fails;
  assign waiting = backlog;

  task automatic report_mismatch(input string what);
    if (fails < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
    fails++;
  endtask

  function automatic void add_event(input logic [1:0] kind, input logic [7:0] tx,
                                    input logic bit_val, input logic drive);
    result_t ev;
    ev.kind     = kind;
    ev.tx_byte  = tx;
    ev.io_bit   = bit_val;
    ev.io_drive = drive;
    ev.last     = 1'b0;
    item_events.push_back(ev);
  endfunction

  // driven clock pulses, lsb first
  function automatic void add_byte_clocks(input logic [7:0] v);
    for (int i = 0; i < 8; i++) add_event(KIND_CLK, 8'h00, v[i], 1'b1);
  endfunction

  function automatic void wire_events_for_item(input logic func, input logic [7:0] rx,
                                               input logic lb);
    item_events.delete();
    if (bridge_mode == MODE_READ) begin
      if (func) begin
        read_shift = {lb, read_shift[7:1]};
        add_event(KIND_CLK, 8'h00, 1'b0, 1'b0);
        if (burst_bit_idx == 3'd7) begin
          burst_bit_idx = 3'd0;
          if (burst_byte_idx + 1 >= BURST_BYTES) begin
            burst_byte_idx = 0;
            bridge_mode = MODE_IDLE;
            add_event(KIND_DRV, 8'h00, 1'b0, 1'b1);
            add_event(KIND_TX, read_shift, 1'b0, 1'b1);
          end else begin
            burst_byte_idx++;
            add_event(KIND_TX, read_shift, 1'b0, 1'b0);
          end
          read_shift = 8'h00;
        end else begin
          burst_bit_idx = burst_bit_idx + 3'd1;
        end
      end
    end else if (bridge_mode == MODE_WRITE) begin
      if (!func) begin
        add_byte_clocks(rx);
        if (burst_byte_idx + 1 >= BURST_BYTES) begin
          burst_byte_idx = 0;
          bridge_mode = MODE_IDLE;
        end else begin
          burst_byte_idx++;
        end
      end
    end else if (!func) begin
      bridge_mode = MODE_IDLE;
      case (rx)
        CMD_ID: begin
          for (int i = 0; i < 8; i++) add_event(KIND_TX, ID_BYTE, 1'b0, 1'b1);
        end
        CMD_RD_CLK, CMD_RD_RAM: begin
          add_event(KIND_CE, 8'h00, 1'b0, 1'b1);
          add_byte_clocks(rx == CMD_RD_CLK ? CODE_RD_CLK : CODE_RD_RAM);
          bridge_mode = MODE_READ;
          burst_byte_idx = 0;
          burst_bit_idx = 3'd0;
          read_shift = 8'h00;
        end
        CMD_WR_CLK, CMD_WR_RAM: begin
          add_event(KIND_CE, 8'h00, 1'b0, 1'b1);
          add_byte_clocks(rx == CMD_WR_CLK ? CODE_WR_CLK : CODE_WR_RAM);
          bridge_mode = MODE_WRITE;
          burst_byte_idx = 0;
          burst_bit_idx = 3'd0;
        end
        default: begin
        end
      endcase
    end
    if (item_events.size() > 0) item_events[item_events.size() - 1].last = 1'b1;
    foreach (item_events[i]) wire_events_due.push_back(item_events[i]);
  endfunction

  task automatic check_event();
    result_t got;
    result_t want;
    got = {out_kind, out_tx_byte, out_io_bit, out_io_drive, out_last};
    if (wire_events_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d tx %02h bit %b drv %b last %b",
                                got.kind, got.tx_byte, got.io_bit, got.io_drive, got.last));
    end else begin
      want = wire_events_due.pop_front();
      if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
          got.io_bit !== want.io_bit || got.io_drive !== want.io_drive ||
          got.last !== want.last)
        report_mismatch($sformatf(
          "got kind %0d tx %02h bit %b drv %b last %b, want kind %0d tx %02h bit %b drv %b last %b",
          got.kind, got.tx_byte, got.io_bit, got.io_drive, got.last,
          want.kind, want.tx_byte, want.io_bit, want.io_drive, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bridge_mode = MODE_IDLE;
      burst_byte_idx = 0;
      burst_bit_idx = 3'd0;
      read_shift = 8'h00;
      wire_events_due.delete();
    end else begin
      if (out_pop && !out_empty) check_event();
      if (in_push && !in_full) wire_events_for_item(in_func, in_rx_byte, in_line_bit);
    end
    backlog <= wire_events_due.size();
  end

endmodule

### tb/sv/uart_to_three_wire_burst_bridge_unit_tb.sv
`timescale 1ns / 100ps

module uart_to_three_wire_burst_bridge_unit_tb;
  import u3wb_pkg::*;

  localparam int RANDOM_ITEMS = 120;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PAT_RANDOM   = 0;
  localparam int PAT_ONES     = 1;
  localparam int PAT_ZEROS    = 2;
  localparam int NUM_PHASES   = 5;
  localparam int SEND_GAP_PCT [NUM_PHASES] = '{0, 64, 0, 28, 0};
  localparam int POP_STALL_PCT[NUM_PHASES] = '{0, 0, 64, 28, 0};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic       in_func = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_line_bit = 1'b0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_tx_byte;
  logic       out_io_bit;
  logic       out_io_drive;
  logic       out_last;

  int errors;
  int waiting;
  int cycles = 0;
  int send_gap_pct = 0;
  int pop_stall_pct = 0;
  int items_sent = 0;

  always #6 clk = ~clk;

  uart_to_three_wire_burst_bridge_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_func      (in_func),
    .in_rx_byte   (in_rx_byte),
    .in_line_bit  (in_line_bit),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_kind     (out_kind),
    .out_tx_byte  (out_tx_byte),
    .out_io_bit   (out_io_bit),
    .out_io_drive (out_io_drive),
    .out_last     (out_last)
  );

  u3wb_event_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_func      (in_func),
    .in_rx_byte   (in_rx_byte),
    .in_line_bit  (in_line_bit),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_kind     (out_kind),
    .out_tx_byte  (out_tx_byte),
    .out_io_bit   (out_io_bit),
    .out_io_drive (out_io_drive),
    .out_last     (out_last),
    .errors       (errors),
    .waiting      (waiting)
  );

  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // push stays high after a transfer until the next call decides on a gap
  task automatic send_item(input logic func, input logic [7:0] rx, input logic lb,
                           input bit counted);
    while ($urandom_range(99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push     <= 1'b1;
    in_func     <= func;
    in_rx_byte  <= rx;
    in_line_bit <= lb;
    do @(posedge clk); while (in_full);
    if (counted) items_sent++;
  endtask

  task automatic wait_all_results();
    in_push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  task automatic read_burst(input logic [7:0] cmd, input int pat);
    logic lb;
    send_item(1'b0, cmd, 1'($urandom_range(1)), 1'b1);
    for (int s = 0; s < BURST_BYTES * 8; s++) begin
      // uart bytes during a read burst are dropped
      if ($urandom_range(19) == 0)
        send_item(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
      if (pat == PAT_ONES) lb = 1'b1;
      else if (pat == PAT_ZEROS) lb = 1'b0;
      else lb = 1'($urandom_range(1));
      send_item(1'b1, 8'($urandom_range(255)), lb, 1'b1);
    end
  endtask

  task automatic write_burst(input logic [7:0] cmd);
    send_item(1'b0, cmd, 1'($urandom_range(1)), 1'b1);
    for (int b = 0; b < BURST_BYTES; b++) begin
      if ($urandom_range(9) == 0)
        send_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
      send_item(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    end
  endtask

  initial begin
    int seq;
    int pick;
    int pat;
    logic [7:0] wr_bytes[8];

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(1'b0, CMD_ID, 1'b1, 1'b1);
    send_item(1'b0, 8'h05, 1'b0, 1'b1);
    send_item(1'b0, 8'hFF, 1'b1, 1'b1);
    send_item(1'b1, 8'h00, 1'b0, 1'b1);
    send_item(1'b1, 8'hFF, 1'b1, 1'b1);
    wr_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hA5, 8'h5A, 8'h02, 8'h7F};
    send_item(1'b0, CMD_WR_RAM, 1'b0, 1'b1);
    foreach (wr_bytes[i]) begin
      if (i == 3) send_item(1'b1, 8'h3C, 1'b1, 1'b1);
      send_item(1'b0, wr_bytes[i], i[0], 1'b1);
    end
    read_burst(CMD_RD_CLK, PAT_ONES);
    send_item(1'b0, CMD_WR_CLK, 1'b1, 1'b1);
    for (int b = 0; b < BURST_BYTES; b++)
      send_item(1'b0, 8'($urandom_range(255)), 1'b0, 1'b1);
    read_burst(CMD_RD_RAM, PAT_ZEROS);
    wait_all_results();

    items_sent = 0;
    seq = 0;
    while (items_sent < RANDOM_ITEMS || seq < NUM_PHASES) begin
      send_gap_pct  = SEND_GAP_PCT[seq % NUM_PHASES];
      pop_stall_pct = POP_STALL_PCT[seq % NUM_PHASES];
      pick = $urandom_range(99);
      if (pick < 30) begin
        pat = $urandom_range(5);
        read_burst(pick < 15 ? CMD_RD_CLK : CMD_RD_RAM,
                   pat == 1 ? PAT_ONES : (pat == 2 ? PAT_ZEROS : PAT_RANDOM));
      end else if (pick < 65) begin
        write_burst(pick < 48 ? CMD_WR_CLK : CMD_WR_RAM);
      end else if (pick < 77) begin
        send_item(1'b0, CMD_ID, 1'($urandom_range(1)), 1'b1);
      end else if (pick < 89) begin
        send_item(1'b0, 8'($urandom_range(255, CMD_WR_RAM + 1)), 1'($urandom_range(1)),
                  1'b1);
      end else begin
        send_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      end
      if (seq % 9 == 8) wait_all_results();
      seq++;
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
